// ===== rtl/core/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int NUM_W     = DATA_W + FRAC_BITS;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} opcode_t;

	// Result fields that are settled in the first stage.
	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              cmp;
		logic              dz;
		logic              is_div;
		logic              neg;
	} side_t;

	// Divider working state: partial remainder, shifting dividend/quotient, divisor.
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [DATA_W-1:0] dvs;
	} divst_t;

	typedef struct packed {
		side_t  side;
		divst_t div;
	} pipe_t;

endpackage

// ===== rtl/core/fpa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface fpa_req_if;
	logic                     valid;
	logic                     ready;
	logic [3:0]               opcode;
	logic signed [31:0]       operand_a;
	logic signed [31:0]       operand_b;

	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic               divide_by_zero;

	modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
	modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

// ===== rtl/core/fpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// First stage: decode, all non-divide results, divider setup.
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [3:0]          opcode,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                valid_s1,
	output fpa_pkg::pipe_t      pipe_s1
);

	logic signed [63:0]         prod;
	logic [31:0]                a_mag;
	logic [31:0]                b_mag;
	fpa_pkg::pipe_t             nxt;

	always_comb begin
		prod  = 64'(operand_a) * 64'(operand_b);
		a_mag = operand_a[31] ? 32'(-operand_a) : operand_a;
		b_mag = operand_b[31] ? 32'(-operand_b) : operand_b;

		nxt             = '0;
		nxt.div.rem     = '0;
		nxt.div.num     = {a_mag, {fpa_pkg::FRAC_BITS{1'b0}}};
		nxt.div.dvs     = b_mag;
		nxt.side.neg    = operand_a[31] ^ operand_b[31];

		case (fpa_pkg::opcode_t'(opcode))
			fpa_pkg::OP_ADD:      nxt.side.res = operand_a + operand_b;
			fpa_pkg::OP_SUB:      nxt.side.res = operand_a - operand_b;
			fpa_pkg::OP_MUL:      nxt.side.res =
				prod[fpa_pkg::FRAC_BITS +: fpa_pkg::DATA_W];
			fpa_pkg::OP_DIV: begin
				nxt.side.is_div = 1'b1;
				nxt.side.dz     = (operand_b == 32'sd0);
			end
			fpa_pkg::OP_GT:       nxt.side.cmp = operand_a >  operand_b;
			fpa_pkg::OP_LT:       nxt.side.cmp = operand_a <  operand_b;
			fpa_pkg::OP_GE:       nxt.side.cmp = operand_a >= operand_b;
			fpa_pkg::OP_LE:       nxt.side.cmp = operand_a <= operand_b;
			fpa_pkg::OP_EQ:       nxt.side.cmp = operand_a == operand_b;
			fpa_pkg::OP_NE:       nxt.side.cmp = operand_a != operand_b;
			fpa_pkg::OP_MIN:      nxt.side.res = (operand_a > operand_b) ? operand_b : operand_a;
			fpa_pkg::OP_MAX:      nxt.side.res = (operand_a < operand_b) ? operand_b : operand_a;
			fpa_pkg::OP_INC:      nxt.side.res = operand_a + 32'sd1;
			fpa_pkg::OP_DEC:      nxt.side.res = operand_a - 32'sd1;
			fpa_pkg::OP_FROM_INT: nxt.side.res = operand_a << fpa_pkg::FRAC_BITS;
			fpa_pkg::OP_TO_INT:   nxt.side.res = operand_a >>> fpa_pkg::FRAC_BITS;
			default:              nxt.side.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/core/fpa_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring-division step (one quotient bit) with its pipeline register.
// ----------------------------------------------------------------------------
module fpa_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fpa_pkg::pipe_t in_pipe,
	output logic           out_valid,
	output fpa_pkg::pipe_t out_pipe
);

	logic [fpa_pkg::DATA_W:0] trial;
	logic [fpa_pkg::DATA_W:0] diff;
	logic                     qbit;
	fpa_pkg::pipe_t           nxt;

	always_comb begin
		trial = {in_pipe.div.rem, in_pipe.div.num[fpa_pkg::NUM_W-1]};
		diff  = trial - {1'b0, in_pipe.div.dvs};
		qbit  = !diff[fpa_pkg::DATA_W];
		nxt   = in_pipe;
		nxt.div.rem = qbit ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
		// shift the dividend out and the quotient bit in
		nxt.div.num = {in_pipe.div.num[fpa_pkg::NUM_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pipe <= nxt;
		end
	end

endmodule

// ===== rtl/core/fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed Q(32-FRAC_BITS).FRAC_BITS ALU with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Takes one operation per clock while the output is not held and returns one
// result per operation, in order. Every operation passes through the same
// stages: one decode stage, one divider stage per quotient bit of the
// 40-bit shifted dividend (eight fractional bits), and the output register.
// The whole pipeline advances together; it holds while a result waits on the output.
// ----------------------------------------------------------------------------
module fixed_point_alu (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);

	logic           en;
	logic           valid_q [fpa_pkg::NUM_W+1];
	fpa_pkg::pipe_t pipe_q  [fpa_pkg::NUM_W+1];
	logic [31:0]    quo;
	logic [31:0]    fin;

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.opcode    (req.opcode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.valid_s1  (valid_q[0]),
		.pipe_s1   (pipe_q[0])
	);

	for (genvar i = 0; i < fpa_pkg::NUM_W; i++) begin : g_div
		fpa_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_q[i]),
			.in_pipe   (pipe_q[i]),
			.out_valid (valid_q[i+1]),
			.out_pipe  (pipe_q[i+1])
		);
	end

	always_comb begin
		quo = pipe_q[fpa_pkg::NUM_W].div.num[31:0];
		if (!pipe_q[fpa_pkg::NUM_W].side.is_div) begin
			fin = pipe_q[fpa_pkg::NUM_W].side.res;
		end else if (pipe_q[fpa_pkg::NUM_W].side.dz) begin
			fin = '0;
		end else if (pipe_q[fpa_pkg::NUM_W].side.neg) begin
			fin = -quo;
		end else begin
			fin = quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= valid_q[fpa_pkg::NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.result_value   <= fin;
			rsp.compare_true   <= pipe_q[fpa_pkg::NUM_W].side.cmp;
			rsp.divide_by_zero <= pipe_q[fpa_pkg::NUM_W].side.dz;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fixed_point_alu: a queued driver and a monitor
// compare every result with a local fixed-point computation, under random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		fpa_pkg::opcode_t   op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_op_t;

	typedef struct {
		logic signed [31:0] value;
		logic               cmp;
		logic               dz;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpa_req_if req ();
	fpa_rsp_if rsp ();

	fixed_point_alu dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #6 clk = ~clk;

	alu_op_t  op_queue[$];
	alu_res_t result_queue[$];
	int       send_idle_pct = 33;
	int       recv_idle_pct = 86;
	int       hold_cycles   = 0;
	int       errors        = 0;
	int       transfers_in  = 0;
	int       transfers_out = 0;
	int       div_zero_seen = 0;

	function automatic alu_res_t compute_alu(alu_op_t t);
		alu_res_t           r;
		logic signed [63:0] wide;
		r.value = '0;
		r.cmp   = 1'b0;
		r.dz    = 1'b0;
		case (t.op)
			fpa_pkg::OP_ADD: r.value = t.a + t.b;
			fpa_pkg::OP_SUB: r.value = t.a - t.b;
			fpa_pkg::OP_MUL: begin
				wide    = 64'(t.a) * 64'(t.b);
				r.value = wide[fpa_pkg::FRAC_BITS +: 32];
			end
			fpa_pkg::OP_DIV: begin
				if (t.b == 0) begin
					r.dz = 1'b1;
				end else begin
					wide    = (64'(t.a) <<< fpa_pkg::FRAC_BITS) / 64'(t.b);
					r.value = wide[31:0];
				end
			end
			fpa_pkg::OP_GT:       r.cmp = t.a > t.b;
			fpa_pkg::OP_LT:       r.cmp = t.a < t.b;
			fpa_pkg::OP_GE:       r.cmp = t.a >= t.b;
			fpa_pkg::OP_LE:       r.cmp = t.a <= t.b;
			fpa_pkg::OP_EQ:       r.cmp = t.a == t.b;
			fpa_pkg::OP_NE:       r.cmp = t.a != t.b;
			fpa_pkg::OP_MIN:      r.value = (t.a > t.b) ? t.b : t.a;
			fpa_pkg::OP_MAX:      r.value = (t.a < t.b) ? t.b : t.a;
			fpa_pkg::OP_INC:      r.value = t.a + 1;
			fpa_pkg::OP_DEC:      r.value = t.a - 1;
			fpa_pkg::OP_FROM_INT: r.value = t.a <<< fpa_pkg::FRAC_BITS;
			default:              r.value = t.a >>> fpa_pkg::FRAC_BITS;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 20)) - 10);
			3: return 32'($urandom_range(0, 4095)) << fpa_pkg::FRAC_BITS;
			4: return {{20{1'b1}}, 12'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(fpa_pkg::opcode_t op, logic [31:0] a, logic [31:0] b);
		alu_op_t t;
		t.op = op;
		t.a  = a;
		t.b  = b;
		op_queue.push_back(t);
	endtask

	// Driver: advance to the next queued transfer when the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid     <= 1'b0;
			req.opcode    <= '0;
			req.operand_a <= '0;
			req.operand_b <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid && req.ready) begin
				result_queue.push_back(compute_alu(op_queue.pop_front()));
				transfers_in++;
			end
			if (op_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req.valid     <= 1'b1;
				req.opcode    <= op_queue[0].op;
				req.operand_a <= op_queue[0].a;
				req.operand_b <= op_queue[0].b;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		alu_res_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				transfers_out++;
				if (rsp.divide_by_zero) div_zero_seen++;
				if (result_queue.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = result_queue.pop_front();
					if (rsp.result_value !== e.value) begin
						$error("result_value exp %h got %h", e.value, rsp.result_value);
						errors++;
					end
					if (rsp.compare_true !== e.cmp) begin
						$error("compare_true exp %b got %b", e.cmp, rsp.compare_true);
						errors++;
					end
					if (rsp.divide_by_zero !== e.dz) begin
						$error("divide_by_zero exp %b got %b", e.dz, rsp.divide_by_zero);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				rsp.ready   <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL fixed_point_alu");
		$finish;
	end

	initial begin
		fpa_pkg::opcode_t op;
		int               guard;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners: every operation, edge operands, zero divisor, overflow.
		for (int k = 0; k < 16; k++) begin
			op = fpa_pkg::opcode_t'(k);
			add_op(op, 32'h8000_0000, 32'h7fff_ffff);
		end
		add_op(fpa_pkg::OP_DIV, 32'h0000_1234, 32'h0);
		add_op(fpa_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
		add_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		add_op(fpa_pkg::OP_DIV, 32'hffff_fd00, 32'h0000_0200);
		add_op(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		add_op(fpa_pkg::OP_MIN, 32'h0000_0500, 32'h0000_0500);
		add_op(fpa_pkg::OP_MAX, 32'hffff_ff00, 32'hffff_ff00);
		add_op(fpa_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
		add_op(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'hffff_ffff);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
			recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 33 : 0;
			if (phase == 2) hold_cycles = 300;
			for (int n = 0; n < 280; n++) begin
				op = fpa_pkg::opcode_t'($urandom_range(0, 15));
				add_op(op, pick_operand(),
					($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
			end
			guard = 0;
			while ((op_queue.size() > 0 || result_queue.size() > 0) && guard < 400_000) begin
				@(posedge clk);
				guard++;
			end
		end
		repeat (100) @(posedge clk);

		$display("Sent %0d operations, checked %0d results, %0d divides by zero.",
			transfers_in, transfers_out, div_zero_seen);
		if (errors == 0 && result_queue.size() == 0 && op_queue.size() == 0) begin
			$display("PASS fixed_point_alu");
		end else begin
			$display("FAIL fixed_point_alu");
		end
		$finish;
	end
endmodule
